>>> rtl/gdc_pkg.sv
// gdc_pkg: shared types, command codes and calendar helpers for the date counter
// used by gdc_alu and gregorian_date_counter_unit; no dependencies
package gdc_pkg;

	localparam int YEAR_BITS_DEF = 16;
	localparam int ALU_W         = 10;
	localparam int IN_TDATA_W    = 16;
	localparam int IN_TUSER_W    = 3;
	localparam int OUT_TDATA_W   = 40;

	localparam logic [2:0] OP_FWD  = 3'd0;
	localparam logic [2:0] OP_BACK = 3'd1;
	localparam logic [2:0] OP_SETY = 3'd2;
	localparam logic [2:0] OP_SETM = 3'd3;
	localparam logic [2:0] OP_SETD = 3'd4;

	localparam logic [3:0] M_JAN = 4'd1;
	localparam logic [3:0] M_FEB = 4'd2;
	localparam logic [3:0] M_APR = 4'd4;
	localparam logic [3:0] M_JUN = 4'd6;
	localparam logic [3:0] M_SEP = 4'd9;
	localparam logic [3:0] M_NOV = 4'd11;
	localparam logic [3:0] M_DEC = 4'd12;

	localparam logic [4:0] D_FIRST = 5'd1;
	localparam logic [4:0] D_LAST  = 5'd31;

	// multiplicative inverse of 25 modulo 2^32, low bits serve narrower years
	localparam logic [31:0] INV_25 = 32'hC28F5C29;

	// operands of the day-of-year adder
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
	} alu_rsp_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == M_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m == M_APR || m == M_JUN || m == M_SEP || m == M_NOV) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

	function automatic logic date_ok(input logic [15:0] d, input logic [15:0] m,
			input logic leap);
		logic ok;
		if (m < 16'd1 || m > 16'(M_DEC)) begin
			ok = 1'b0;
		end else begin
			ok = (d >= 16'd1) && (d <= 16'(month_len(m[3:0], leap)));
		end
		return ok;
	endfunction

endpackage

>>> rtl/gdc_alu.sv
// gdc_alu: adder for the day-of-year sum
// one month length is added per use; depends on gdc_pkg
module gdc_alu
	import gdc_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	assign rsp.sum = req.a + req.b;

endmodule

>>> rtl/gregorian_date_counter_unit.sv
// gregorian_date_counter_unit: top level of the calendar date counter
// sequencer, date registers and output register; depends on gdc_pkg and gdc_alu
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tuser = op, s_tdata = value
// m_       out  m_tvalid/m_tready   m_tdata = day, month, year, ordinal, leap, rejected
//
// one command beat at a time; s_tready is high only while the sequencer is idle
// a command runs from accept through decode, the day-of-year sum over the months up
// to the current one and the hand-off; a step across a year end also passes the leap
// test of the new year, and a set year that fits passes the leap test, then validation
// the leap test multiplies the year by the inverse of 25 to spot century years
// the result waits in the output register until taken; meanwhile the next command
// runs up to its hand-off state and holds there; reset gives january 1, 2000
module gregorian_date_counter_unit
	import gdc_pkg::*;
#(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] value
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // [2:0] op
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [4:0] day_now, [8:5] month_now,
	                                          // [24:9] year_now, [33:25] ordinal_day,
	                                          // [34] leap, [35] rejected, [39:36] zero
);

	// a year is a multiple of 25 when year * inverse stays at or below this bound
	localparam logic [YEAR_BITS-1:0] INV25_Y = YEAR_BITS'(INV_25);
	localparam logic [YEAR_BITS-1:0] LIM25_Y =
		YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;  // decode command, simple updates
	localparam logic [2:0] S_LEAP  = 3'd2;  // leap test of a new year
	localparam logic [2:0] S_CHK   = 3'd3;  // validate a new year
	localparam logic [2:0] S_OINIT = 3'd4;  // seed the day-of-year sum
	localparam logic [2:0] S_OSUM  = 3'd5;  // add one month length per cycle
	localparam logic [2:0] S_DONE  = 3'd6;  // hand the result to the output register

	logic [2:0]           state_q;
	logic [4:0]           day_q;
	logic [3:0]           month_q;
	logic [YEAR_BITS-1:0] year_q;
	logic                 leap_q;
	logic                 rej_q;
	logic [2:0]           op_q;
	logic [15:0]          val_q;
	logic [YEAR_BITS-1:0] tgt_q;      // new year under test
	logic                 tleap_q;    // leap flag of tgt_q
	logic [8:0]           ord_q;
	logic [3:0]           mcnt_q;
	logic                 m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	logic [YEAR_BITS-1:0] tgt_prod;
	logic                 tgt_div25;
	logic                 tgt_leap;
	logic [YEAR_BITS-1:0] year_inc;
	logic [YEAR_BITS-1:0] year_dec;
	logic [31:0]          val_ext;
	logic                 val_fits;
	logic [4:0]           cur_len;
	logic [3:0]           month_dec;
	logic                 dec_to_leap;
	logic                 out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign year_inc  = year_q + YEAR_BITS'(1);
	assign year_dec  = year_q - YEAR_BITS'(1);
	assign cur_len   = month_len(month_q, leap_q);
	assign month_dec = month_q - 4'd1;

	// a set year must fit the year register
	assign val_ext  = 32'(val_q);
	assign val_fits = ((val_ext >> YEAR_BITS) == 32'd0);

	// divisible by 4 is leap, unless a multiple of 100 that is not a multiple of 400;
	// with 4 | y, a multiple of 100 is a multiple of 25, and of 400 when 16 | y too
	assign tgt_prod  = tgt_q * INV25_Y;
	assign tgt_div25 = (tgt_prod <= LIM25_Y);
	assign tgt_leap  = (tgt_q[1:0] == 2'b00) && (!tgt_div25 || tgt_q[3:0] == 4'd0);

	// commands that bring in a new year go through the leap test
	assign dec_to_leap = (op_q == OP_FWD && day_q >= cur_len && month_q >= M_DEC)
		|| (op_q == OP_BACK && day_q <= D_FIRST && month_q <= M_JAN)
		|| (op_q == OP_SETY && val_fits);

	// the adder accumulates month lengths
	always_comb begin
		alu_req.a = {1'b0, ord_q};
		alu_req.b = ALU_W'(month_len(mcnt_q, leap_q));
	end

	gdc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			day_q      <= D_FIRST;
			month_q    <= M_JAN;
			year_q     <= YEAR_BITS'(2000);
			leap_q     <= 1'b1;
			rej_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a beat taken while the next one is handed over keeps m_tvalid high
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						rej_q   <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= dec_to_leap ? S_LEAP : S_OINIT;
					unique case (op_q)
						OP_FWD: begin
							if (day_q >= cur_len) begin
								day_q <= D_FIRST;
								if (month_q >= M_DEC) begin
									// new year's day
									month_q <= M_JAN;
									year_q  <= year_inc;
								end else begin
									month_q <= month_q + 4'd1;
								end
							end else begin
								day_q <= day_q + 5'd1;
							end
						end
						OP_BACK: begin
							if (day_q <= D_FIRST) begin
								if (month_q <= M_JAN) begin
									// back to december 31 of the previous year
									month_q <= M_DEC;
									day_q   <= D_LAST;
									year_q  <= year_dec;
								end else begin
									month_q <= month_dec;
									day_q   <= month_len(month_dec, leap_q);
								end
							end else begin
								day_q <= day_q - 5'd1;
							end
						end
						OP_SETY: begin
							if (!val_fits) begin
								rej_q <= 1'b1;
							end
						end
						OP_SETM: begin
							if (date_ok(16'(day_q), val_q, leap_q)) begin
								month_q <= val_q[3:0];
							end else begin
								rej_q <= 1'b1;
							end
						end
						OP_SETD: begin
							if (date_ok(val_q, 16'(month_q), leap_q)) begin
								day_q <= val_q[4:0];
							end else begin
								rej_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				S_LEAP: begin
					if (op_q == OP_SETY) begin
						state_q <= S_CHK;
					end else begin
						leap_q  <= tgt_leap;
						state_q <= S_OINIT;
					end
				end
				S_CHK: begin
					// only february 29 depends on the new year
					if (date_ok(16'(day_q), 16'(month_q), tleap_q)) begin
						year_q <= tgt_q;
						leap_q <= tleap_q;
					end else begin
						rej_q <= 1'b1;
					end
					state_q <= S_OINIT;
				end
				S_OINIT: begin
					state_q <= S_OSUM;
				end
				S_OSUM: begin
					if (mcnt_q >= month_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q  <= s_tuser;
			val_q <= s_tdata;
		end
		if (state_q == S_DEC) begin
			if (op_q == OP_FWD) begin
				tgt_q <= year_inc;
			end else if (op_q == OP_BACK) begin
				tgt_q <= year_dec;
			end else begin
				tgt_q <= YEAR_BITS'(val_q);
			end
		end
		if (state_q == S_LEAP) begin
			tleap_q <= tgt_leap;
		end
		if (state_q == S_OINIT) begin
			ord_q  <= 9'(day_q);
			mcnt_q <= M_JAN;
		end
		if (state_q == S_OSUM && mcnt_q < month_q) begin
			ord_q  <= alu_rsp.sum[8:0];
			mcnt_q <= mcnt_q + 4'd1;
		end
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {4'b0000, rej_q, leap_q, ord_q, 16'(year_q), month_q, day_q};
		end
	end

endmodule
